// File: hdl/sem_pkg.sv
// Shared constants, types and the arctangent table for the elevation mask block.
// Depends on nothing; every other file imports this package.
`timescale 1ns / 1ps

package sem_pkg;

  // Default coordinate width in bits.
  localparam int COORD_BITS_DEF = 27;

  // Normalized magnitude width and signed width of the scaled vector terms.
  localparam int NORM_BITS = 30;
  localparam int NW        = NORM_BITS + 1;

  // Integer square root: one result bit per stage.
  localparam int ROOT_STEPS = 31;

  // CORDIC datapath widths and number of iterations.
  localparam int XW           = 34;
  localparam int ZW           = 29;
  localparam int CORDIC_STEPS = 27;
  localparam int ANGLE_FRAC   = 20;
  localparam int DEG_SCALE    = 100;

  // Angle and mask format, hundredths of a degree.
  localparam int ELEV_W     = 15;
  localparam int MASK_W     = 15;
  localparam int ELEV_MAX   = 9000;
  localparam int MASK_RESET = 1000;

  // Control that travels with each word through the pipeline.
  typedef struct packed {
    logic valid;
    logic degen;
  } sem_ctl_t;

  // atan(2^-i) in degrees, scaled by 2^20 and rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0:  t = ZW'(47185920);
      1:  t = ZW'(27855475);
      2:  t = ZW'(14718068);
      3:  t = ZW'(7471121);
      4:  t = ZW'(3750058);
      5:  t = ZW'(1876857);
      6:  t = ZW'(938658);
      7:  t = ZW'(469357);
      8:  t = ZW'(234682);
      9:  t = ZW'(117342);
      10: t = ZW'(58671);
      11: t = ZW'(29335);
      12: t = ZW'(14668);
      13: t = ZW'(7334);
      14: t = ZW'(3667);
      15: t = ZW'(1833);
      16: t = ZW'(917);
      17: t = ZW'(458);
      18: t = ZW'(229);
      19: t = ZW'(115);
      20: t = ZW'(57);
      21: t = ZW'(29);
      22: t = ZW'(14);
      23: t = ZW'(7);
      24: t = ZW'(4);
      25: t = ZW'(2);
      26: t = ZW'(1);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// File: hdl/sem_if.sv
// Valid/ready channel interfaces for position words and elevation words.
// Depends on sem_pkg for the result field widths.
`timescale 1ns / 1ps

interface sem_in_if import sem_pkg::*; #(
  parameter int CB = COORD_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] station_x;
  logic signed [CB-1:0] station_y;
  logic signed [CB-1:0] station_z;
  logic signed [CB-1:0] sat_x;
  logic signed [CB-1:0] sat_y;
  logic signed [CB-1:0] sat_z;

  modport source (
    output valid, station_x, station_y, station_z, sat_x, sat_y, sat_z,
    input  ready
  );
  modport sink (
    input  valid, station_x, station_y, station_z, sat_x, sat_y, sat_z,
    output ready
  );
endinterface

interface sem_out_if import sem_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEV_W-1:0] elevation;
  logic                     visible;
  logic                     degenerate;

  modport source (output valid, elevation, visible, degenerate, input ready);
  modport sink   (input valid, elevation, visible, degenerate, output ready);
endinterface

// File: hdl/sem_front.sv
// Front end: line of sight, exact dot and cross products, common normalization.
// Depends on sem_pkg; six register stages, all advancing on adv.
`timescale 1ns / 1ps

module sem_front import sem_pkg::*; #(
  parameter int CB = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [CB-1:0] station_x,
  input  logic signed [CB-1:0] station_y,
  input  logic signed [CB-1:0] station_z,
  input  logic signed [CB-1:0] sat_x,
  input  logic signed [CB-1:0] sat_y,
  input  logic signed [CB-1:0] sat_z,
  output sem_ctl_t             out_ctl,
  output logic signed [NW-1:0] norm [4]
);

  localparam int PW  = 2 * CB + 1;
  localparam int VW  = 2 * CB + 3;
  localparam int LZW = $clog2(VW + 1);

  // Leading zeros of a magnitude word; VW for an all-zero word.
  function automatic logic [LZW-1:0] lead_zeros(input logic [VW-1:0] w);
    logic [LZW-1:0] n;
    n = LZW'(VW);
    for (int k = 0; k < VW; k++) begin
      if (w[k]) n = LZW'(VW - 1 - k);
    end
    return n;
  endfunction

  sem_ctl_t ca, cb, cc, cd, ce;

  logic signed [CB-1:0] ga [3];
  logic signed [CB-1:0] sa [3];
  logic signed [CB:0]   da [3];
  logic signed [PW-1:0] pb [9];
  logic signed [VW-1:0] vc [4];
  logic [VW-1:0]        md [4];
  logic [3:0]           sd;
  logic [VW-1:0]        ord;
  logic [VW-1:0]        me [4];
  logic [3:0]           se;
  logic [LZW-1:0]       le;

  logic                 degen_in;
  logic [VW-1:0]        mag_c [4];
  logic [VW-1:0]        or_c;
  logic [VW-1:0]        shf_c [4];
  logic [NORM_BITS-1:0] nmag_c [4];

  // A zero station vector or a satellite on the station gives no geometry.
  assign degen_in = (station_x == '0 && station_y == '0 && station_z == '0) ||
                    (sat_x == station_x && sat_y == station_y && sat_z == station_z);

  // Magnitudes and their common OR for the normalization search.
  always_comb begin
    or_c = '0;
    for (int i = 0; i < 4; i++) begin
      mag_c[i] = vc[i][VW-1] ? VW'(-vc[i]) : VW'(vc[i]);
      or_c     = or_c | mag_c[i];
    end
  end

  // Put the highest set bit of the group at the top and keep NORM_BITS bits.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      shf_c[i]  = me[i] << le;
      nmag_c[i] = shf_c[i][VW-1 -: NORM_BITS];
    end
  end

  // Control pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      ca      <= '0;
      cb      <= '0;
      cc      <= '0;
      cd      <= '0;
      ce      <= '0;
      out_ctl <= '0;
    end else if (adv) begin
      ca      <= '{valid: in_valid, degen: degen_in};
      cb      <= ca;
      cc      <= cb;
      cd      <= cc;
      ce      <= cd;
      out_ctl <= ce;
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      // Capture the positions and form the line of sight.
      ga[0] <= station_x;
      ga[1] <= station_y;
      ga[2] <= station_z;
      sa[0] <= sat_x;
      sa[1] <= sat_y;
      sa[2] <= sat_z;
      da[0] <= (CB+1)'(sat_x) - (CB+1)'(station_x);
      da[1] <= (CB+1)'(sat_y) - (CB+1)'(station_y);
      da[2] <= (CB+1)'(sat_z) - (CB+1)'(station_z);

      // Nine products for the dot product and the cross product G x S.
      pb[0] <= PW'(ga[0]) * PW'(da[0]);
      pb[1] <= PW'(ga[1]) * PW'(da[1]);
      pb[2] <= PW'(ga[2]) * PW'(da[2]);
      pb[3] <= PW'(ga[1]) * PW'(sa[2]);
      pb[4] <= PW'(ga[2]) * PW'(sa[1]);
      pb[5] <= PW'(ga[2]) * PW'(sa[0]);
      pb[6] <= PW'(ga[0]) * PW'(sa[2]);
      pb[7] <= PW'(ga[0]) * PW'(sa[1]);
      pb[8] <= PW'(ga[1]) * PW'(sa[0]);

      // Sums and differences.
      vc[0] <= VW'(pb[0]) + VW'(pb[1]) + VW'(pb[2]);
      vc[1] <= VW'(pb[3]) - VW'(pb[4]);
      vc[2] <= VW'(pb[5]) - VW'(pb[6]);
      vc[3] <= VW'(pb[7]) - VW'(pb[8]);

      // Split into sign and magnitude.
      for (int i = 0; i < 4; i++) begin
        md[i] <= mag_c[i];
        sd[i] <= vc[i][VW-1];
      end
      ord <= or_c;

      // Leading-zero count of the group.
      me <= md;
      se <= sd;
      le <= lead_zeros(ord);

      // Scaled values with their signs restored.
      for (int i = 0; i < 4; i++) begin
        norm[i] <= se[i] ? -$signed({1'b0, nmag_c[i]}) : $signed({1'b0, nmag_c[i]});
      end
    end
  end

endmodule

// File: hdl/sem_isqrt.sv
// Pipelined integer square root of the cross product's squared length.
// Depends on sem_pkg; two setup stages and one stage per result bit.
`timescale 1ns / 1ps

module sem_isqrt import sem_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  sem_ctl_t             in_ctl,
  input  logic signed [NW-1:0] norm [4],
  output sem_ctl_t             out_ctl,
  output logic signed [NW-1:0] dot,
  output logic [NW-1:0]        root
);

  localparam int QW = 2 * NW;
  localparam int RW = QW + 1;

  sem_ctl_t             cs;
  logic signed [NW-1:0] ds;
  logic [QW-1:0]        sq [3];

  sem_ctl_t             cp  [ROOT_STEPS+1];
  logic signed [NW-1:0] dp  [ROOT_STEPS+1];
  logic [RW-1:0]        rem [ROOT_STEPS+1];
  logic [RW-1:0]        res [ROOT_STEPS+1];

  // Squares of the cross product terms, then their sum.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= $unsigned(QW'(norm[i+1]) * QW'(norm[i+1]));
      end
      ds     <= norm[0];
      rem[0] <= RW'(sq[0]) + RW'(sq[1]) + RW'(sq[2]);
      res[0] <= '0;
      dp[0]  <= ds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cs    <= '0;
      cp[0] <= '0;
    end else if (adv) begin
      cs    <= in_ctl;
      cp[0] <= cs;
    end
  end

  // One result bit per stage, most significant first.
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (ROOT_STEPS - 1 - k));
    logic [RW-1:0] trial;

    assign trial = res[k] + BIT;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          res[k+1] <= (res[k] >> 1) + BIT;
        end else begin
          rem[k+1] <= rem[k];
          res[k+1] <= res[k] >> 1;
        end
        dp[k+1] <= dp[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cp[k+1] <= '0;
      end else if (adv) begin
        cp[k+1] <= cp[k];
      end
    end
  end

  assign out_ctl = cp[ROOT_STEPS];
  assign dot     = dp[ROOT_STEPS];
  assign root    = res[ROOT_STEPS][NW-1:0];

endmodule

// File: hdl/sem_cordic.sv
// Vectoring CORDIC for the elevation angle, scaling to hundredths and the mask test.
// Depends on sem_pkg; one stage per iteration plus setup, scale and output stages.
`timescale 1ns / 1ps

module sem_cordic import sem_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  sem_ctl_t                 in_ctl,
  input  logic signed [NW-1:0]     dot,
  input  logic [NW-1:0]            root,
  input  logic signed [MASK_W-1:0] mask,
  output logic                     out_valid,
  output logic signed [ELEV_W-1:0] elevation,
  output logic                     visible,
  output logic                     degenerate
);

  localparam int PRW = ZW + 7;
  localparam int EMW = PRW - ANGLE_FRAC;

  // Control plus the special cases decided before the iterations.
  typedef struct packed {
    logic valid;
    logic degen;
    logic dot_zero;
    logic root_zero;
    logic dot_neg;
  } flags_t;

  flags_t               fl [CORDIC_STEPS+1];
  logic signed [XW-1:0] x  [CORDIC_STEPS+1];
  logic signed [XW-1:0] y  [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z  [CORDIC_STEPS+1];

  flags_t               fm;
  logic                 zneg_m;
  logic [PRW-1:0]       prod_m;

  logic [ZW-1:0]            zmag_c;
  logic [EMW-1:0]           esc_c;
  logic [EMW-1:0]           eclamp_c;
  logic signed [ELEV_W-1:0] e_c;

  // Setup stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      x[0] <= XW'($signed({1'b0, root}));
      y[0] <= XW'(dot);
      z[0] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fl[0] <= '0;
    end else if (adv) begin
      fl[0] <= '{valid: in_ctl.valid, degen: in_ctl.degen, dot_zero: dot == '0,
                 root_zero: root == '0, dot_neg: dot[NW-1]};
    end
  end

  // One rotation per stage, steering y toward zero.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] T = atan_step(i);
    logic signed [XW-1:0] xs, ys;

    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!y[i][XW-1]) begin
          x[i+1] <= x[i] + ys;
          y[i+1] <= y[i] - xs;
          z[i+1] <= z[i] + T;
        end else begin
          x[i+1] <= x[i] - ys;
          y[i+1] <= y[i] + xs;
          z[i+1] <= z[i] - T;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        fl[i+1] <= '0;
      end else if (adv) begin
        fl[i+1] <= fl[i];
      end
    end
  end

  // Scale the angle magnitude to hundredths of a degree.
  assign zmag_c = z[CORDIC_STEPS][ZW-1] ? ZW'(-z[CORDIC_STEPS]) : ZW'(z[CORDIC_STEPS]);

  always_ff @(posedge clk) begin
    if (adv) begin
      zneg_m <= z[CORDIC_STEPS][ZW-1];
      prod_m <= PRW'(zmag_c) * PRW'(DEG_SCALE);
    end
  end

  // Truncate, clamp and pick the special cases.
  always_comb begin
    esc_c    = prod_m[ANGLE_FRAC +: EMW];
    eclamp_c = (esc_c > EMW'(ELEV_MAX)) ? EMW'(ELEV_MAX) : esc_c;
    if (fm.degen || fm.dot_zero) begin
      e_c = '0;
    end else if (fm.root_zero) begin
      e_c = fm.dot_neg ? -ELEV_W'(ELEV_MAX) : ELEV_W'(ELEV_MAX);
    end else begin
      e_c = zneg_m ? -ELEV_W'(eclamp_c) : ELEV_W'(eclamp_c);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      elevation  <= e_c;
      visible    <= !fm.degen && (e_c > mask);
      degenerate <= fm.degen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fm        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      fm        <= fl[CORDIC_STEPS];
      out_valid <= fm.valid;
    end
  end

endmodule

// File: hdl/satellite_elevation_mask.sv
// Top level of the satellite elevation mask block.
// Depends on sem_pkg, sem_if, sem_front, sem_isqrt and sem_cordic.
//
// Each word on the sample channel holds a ground station and a satellite
// position in Earth-centred metres. Each word on the result channel gives the
// elevation of the satellite above the station horizon in hundredths of a
// degree, truncated toward zero, a visible flag when the elevation exceeds the
// mask, and a degenerate flag when the station is at the origin or the
// satellite sits on the station (elevation and visible are then zero).
// The user must write the mask (cfg_we, cfg_data) only while idle; the block
// does not enforce this. Throughput is one word per cycle while results are
// taken; a word passes six front-end stages, 33 square-root stages (one per
// root bit plus two) and 30 CORDIC stages (one per iteration plus three).
// The whole pipeline advances together: when the result word is not taken,
// every stage holds and sample.ready drops, so nothing is lost or repeated.
// Synchronous reset empties the pipeline and restores the mask to 10 degrees.
`timescale 1ns / 1ps

module satellite_elevation_mask import sem_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  sem_in_if.sink            sample,
  sem_out_if.source         result,
  input  logic              cfg_we,
  input  logic [MASK_W-1:0] cfg_data
);

  logic                     adv;
  logic signed [MASK_W-1:0] mask;

  sem_ctl_t             front_ctl, root_ctl;
  logic signed [NW-1:0] norm [4];
  logic signed [NW-1:0] dot;
  logic [NW-1:0]        root;

  // Advance whenever the output register is empty or being taken.
  assign adv          = !result.valid || result.ready;
  assign sample.ready = adv;

  // Mask register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= MASK_W'(MASK_RESET);
    end else if (cfg_we) begin
      mask <= $signed(cfg_data);
    end
  end

  sem_front #(.CB(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sample.valid),
    .station_x (sample.station_x),
    .station_y (sample.station_y),
    .station_z (sample.station_z),
    .sat_x     (sample.sat_x),
    .sat_y     (sample.sat_y),
    .sat_z     (sample.sat_z),
    .out_ctl   (front_ctl),
    .norm      (norm)
  );

  sem_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_ctl  (front_ctl),
    .norm    (norm),
    .out_ctl (root_ctl),
    .dot     (dot),
    .root    (root)
  );

  sem_cordic u_cordic (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_ctl     (root_ctl),
    .dot        (dot),
    .root       (root),
    .mask       (mask),
    .out_valid  (result.valid),
    .elevation  (result.elevation),
    .visible    (result.visible),
    .degenerate (result.degenerate)
  );

endmodule

// File: hdl/sem_checker.sv
// Port-level assertions for the satellite elevation mask block.
// Depends on sem_pkg; bound to satellite_elevation_mask below.
`timescale 1ns / 1ps

module sem_checker import sem_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [ELEV_W-1:0] elevation,
  input logic                     visible,
  input logic                     degenerate,
  input logic                     cfg_we,
  input logic [MASK_W-1:0]        cfg_data
);

  logic signed [MASK_W-1:0] mask;

  // Shadow of the mask register as seen on the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= MASK_W'(MASK_RESET);
    end else if (cfg_we) begin
      mask <= $signed(cfg_data);
    end
  end

  // An empty output stage always accepts a new word.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("sample not ready while the output stage is empty");

  // A degenerate word carries no angle and is never visible.
  a_degen_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> elevation == '0 && !visible)
    else $error("degenerate word with nonzero angle or visible set");

  // The angle stays within a quarter turn.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> elevation <= ELEV_W'(ELEV_MAX) && elevation >= -ELEV_W'(ELEV_MAX))
    else $error("elevation outside -90..90 degrees");

  // Visible agrees with the mask comparison.
  a_visible: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> visible == (!degenerate && elevation > mask))
    else $error("visible does not match the mask comparison");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(elevation) && $stable(visible))
    else $error("result word changed while stalled");

endmodule

bind satellite_elevation_mask sem_checker u_sem_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (sample.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .elevation  (result.elevation),
  .visible    (result.visible),
  .degenerate (result.degenerate),
  .cfg_we     (cfg_we),
  .cfg_data   (cfg_data)
);

// File: dv/satellite_elevation_mask_tb.sv
// Self-checking testbench for the satellite elevation mask block.
// Depends on sem_pkg, sem_if and the satellite_elevation_mask RTL.
// Drives directed geometry, then random position pairs under several masks.
`timescale 1ns / 1ps

module satellite_elevation_mask_tb import sem_pkg::*; ();

  localparam int CB       = 27;
  localparam int LATENCY  = 69;
  localparam int LIMIT    = 600000;
  localparam int SEG_LEN  = 316;
  localparam int EARTH_R  = 6378137;
  localparam int CRD_MAX  = 67108863;
  localparam int CRD_MIN  = -67108864;

  // atan(2^-i) in degrees, scaled by 2^20.
  localparam longint ATAN_DEG[27] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
    469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917,
    458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

  typedef struct packed {
    logic signed [CB-1:0] gx, gy, gz, sx, sy, sz;
  } geom_t;

  typedef struct packed {
    logic signed [ELEV_W-1:0] elevation;
    logic                     visible;
    logic                     degenerate;
  } elev_t;

  typedef struct {
    geom_t p;
    bit    typed;
    elev_t r;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [MASK_W-1:0] cfg_data;

  sem_in_if #(.CB(CB)) sample_ch ();
  sem_out_if result_ch ();

  satellite_elevation_mask #(.COORD_BITS(CB)) dut (
    .clk(clk),
    .rst(rst),
    .sample(sample_ch),
    .result(result_ch),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  logic signed [MASK_W-1:0] mask_setting;
  elev_t pending_elev[$];
  int tx_idle_pct;
  int rx_idle_pct;
  int errors;
  int words_checked;
  int mask_writes;
  longint cycles;

  // Directed geometry: straight up, straight down, horizon, zero vectors, extremes.
  dir_row_t dir_rows[] = '{
    '{'{EARTH_R, 0, 0, 2*EARTH_R, 0, 0}, 1, '{9000, 1, 0}},
    '{'{EARTH_R, 0, 0, -EARTH_R, 0, 0}, 1, '{-9000, 0, 0}},
    '{'{EARTH_R, 0, 0, EARTH_R, EARTH_R, 0}, 1, '{0, 0, 0}},
    '{'{0, 0, 0, 1000, 2000, 3000}, 1, '{0, 0, 1}},
    '{'{EARTH_R, 5, -7, EARTH_R, 5, -7}, 1, '{0, 0, 1}},
    '{'{0, 0, 0, 0, 0, 0}, 1, '{0, 0, 1}},
    '{'{CRD_MAX, CRD_MAX, CRD_MAX, CRD_MIN, CRD_MIN, CRD_MIN}, 0, '{0, 0, 0}},
    '{'{CRD_MIN, CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX, CRD_MAX}, 0, '{0, 0, 0}},
    '{'{CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN}, 1, '{0, 0, 1}},
    '{'{1, 0, 0, 1, 0, 1}, 1, '{0, 0, 0}},
    '{'{0, 0, -EARTH_R, 0, 0, -2*EARTH_R}, 1, '{9000, 1, 0}},
    '{'{CRD_MAX, 0, 0, CRD_MIN, 0, 0}, 1, '{-9000, 0, 0}},
    '{'{1, 1, 1, 2, 2, 2}, 1, '{9000, 1, 0}},
    '{'{-1, -1, -1, 0, 0, 0}, 1, '{-9000, 0, 0}},
    '{'{EARTH_R, 0, 0, EARTH_R + 1000, 0, 1000}, 0, '{0, 0, 0}},
    '{'{0, EARTH_R, 0, 100, EARTH_R + 1, 0}, 0, '{0, 0, 0}},
    '{'{4000000, -3000000, 3500000, 20000000, -15000000, 10000000}, 0, '{0, 0, 0}},
    '{'{CRD_MAX, CRD_MIN, 1, -1, CRD_MAX, CRD_MIN}, 0, '{0, 0, 0}}
  };

  // Elevation of the satellite above the station horizon, exact fixed point.
  function automatic elev_t predict_elevation(geom_t p, logic signed [MASK_W-1:0] m);
    logic signed [127:0] gw[3];
    logic signed [127:0] sw[3];
    logic signed [127:0] dw[3];
    logic signed [127:0] v[4];
    logic [127:0] mg[4];
    logic [127:0] orv;
    logic [127:0] sc;
    int top, rs, ls;
    longint n[4];
    longint unsigned q, bitv, root;
    longint x, y, z, xs, ys, e;
    elev_t r;
    gw[0] = 128'(p.gx); gw[1] = 128'(p.gy); gw[2] = 128'(p.gz);
    sw[0] = 128'(p.sx); sw[1] = 128'(p.sy); sw[2] = 128'(p.sz);
    for (int i = 0; i < 3; i++) dw[i] = sw[i] - gw[i];
    if ((gw[0] == 0 && gw[1] == 0 && gw[2] == 0) ||
        (dw[0] == 0 && dw[1] == 0 && dw[2] == 0)) begin
      r.elevation = '0;
      r.visible = 1'b0;
      r.degenerate = 1'b1;
      return r;
    end
    // Dot product with the line of sight and the cross product G x S.
    v[0] = gw[0] * dw[0] + gw[1] * dw[1] + gw[2] * dw[2];
    v[1] = gw[1] * sw[2] - gw[2] * sw[1];
    v[2] = gw[2] * sw[0] - gw[0] * sw[2];
    v[3] = gw[0] * sw[1] - gw[1] * sw[0];
    orv = '0;
    for (int i = 0; i < 4; i++) begin
      mg[i] = v[i][127] ? -v[i] : v[i];
      orv |= mg[i];
    end
    top = 0;
    for (int b = 0; b < 128; b++) if (orv[b]) top = b + 1;
    rs = (top > 30) ? top - 30 : 0;
    ls = (top > 30) ? 0 : 30 - top;
    // Normalize all four terms together so the largest lands in [2^29, 2^30).
    for (int i = 0; i < 4; i++) begin
      sc = (rs > 0) ? (mg[i] >> rs) : (mg[i] << ls);
      n[i] = v[i][127] ? -longint'(sc[63:0]) : longint'(sc[63:0]);
    end
    q = n[1] * n[1] + n[2] * n[2] + n[3] * n[3];
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > q) bitv >>= 2;
    while (bitv != 0) begin
      if (q >= root + bitv) begin
        q -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (n[0] == 0) begin
      e = 0;
    end else if (root == 0) begin
      e = (n[0] > 0) ? longint'(ELEV_MAX) : -longint'(ELEV_MAX);
    end else begin
      // Vectoring rotation drives y to zero and accumulates the angle in z.
      x = root; y = n[0]; z = 0;
      for (int i = 0; i < 27; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += ATAN_DEG[i];
        end else begin
          x -= ys; y += xs; z -= ATAN_DEG[i];
        end
      end
      e = (((z < 0) ? -z : z) * 100) >>> 20;
      if (z < 0) e = -e;
      if (e > ELEV_MAX) e = longint'(ELEV_MAX);
      if (e < -ELEV_MAX) e = -longint'(ELEV_MAX);
    end
    r.elevation = e[ELEV_W-1:0];
    r.visible = (e > longint'(m));
    r.degenerate = 1'b0;
    return r;
  endfunction

  function automatic int rand_span(int lo, int hi);
    return int'($urandom_range(0, hi - lo)) + lo;
  endfunction

  // Raw random bits in every coordinate.
  function automatic geom_t raw_geom();
    geom_t p;
    p.gx = CB'($urandom);
    p.gy = CB'($urandom);
    p.gz = CB'($urandom);
    p.sx = CB'($urandom);
    p.sy = CB'($urandom);
    p.sz = CB'($urandom);
    return p;
  endfunction

  // Mostly realistic station and satellite pairs, plus raw and corner geometry.
  function automatic geom_t random_geom();
    geom_t p;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      p.gx = CB'(rand_span(-EARTH_R, EARTH_R));
      p.gy = CB'(rand_span(-EARTH_R, EARTH_R));
      p.gz = CB'(rand_span(-EARTH_R, EARTH_R));
      p.sx = CB'(rand_span(-42164000, 42164000));
      p.sy = CB'(rand_span(-42164000, 42164000));
      p.sz = CB'(rand_span(-42164000, 42164000));
    end else if (kind < 80) begin
      p = raw_geom();
    end else if (kind < 88) begin
      p.gx = CB'(rand_span(-8, 8)); p.gy = CB'(rand_span(-8, 8));
      p.gz = CB'(rand_span(-8, 8));
      p.sx = CB'(rand_span(-8, 8)); p.sy = CB'(rand_span(-8, 8));
      p.sz = CB'(rand_span(-8, 8));
    end else if (kind < 92) begin
      p = raw_geom();
      p.gx = '0; p.gy = '0; p.gz = '0;
    end else if (kind < 96) begin
      p = raw_geom();
      p.sx = p.gx; p.sy = p.gy; p.sz = p.gz;
    end else begin
      p = raw_geom();
      p.sx = CB'(p.gx + rand_span(-1, 1));
      p.sy = CB'(p.gy + rand_span(-1, 1));
      p.sz = p.gz;
    end
    return p;
  endfunction

  // Clock and cycle limit.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(negedge clk) begin
    if (rst) result_ch.ready <= 1'b0;
    else result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Compare each result word with the oldest expected word.
  always @(posedge clk) begin
    elev_t got, want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = '{result_ch.elevation, result_ch.visible, result_ch.degenerate};
      if (pending_elev.size() == 0) begin
        $error("Result word with no expected word waiting");
        errors++;
      end else begin
        want = pending_elev.pop_front();
        words_checked++;
        if (got.elevation !== want.elevation) begin
          $error("elevation mismatch: expected %0d, got %0d",
                 want.elevation, got.elevation);
          errors++;
        end
        if (got.visible !== want.visible) begin
          $error("visible mismatch: expected %0d, got %0d", want.visible, got.visible);
          errors++;
        end
        if (got.degenerate !== want.degenerate) begin
          $error("degenerate mismatch: expected %0d, got %0d",
                 want.degenerate, got.degenerate);
          errors++;
        end
      end
    end
  end

  // Offer one word, hold it until accepted, and record its expected result.
  task automatic send_word(geom_t p, bit typed, elev_t typed_r);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.station_x <= p.gx;
    sample_ch.station_y <= p.gy;
    sample_ch.station_z <= p.gz;
    sample_ch.sat_x <= p.sx;
    sample_ch.sat_y <= p.sy;
    sample_ch.sat_z <= p.sz;
    do @(posedge clk); while (!sample_ch.ready);
    pending_elev.push_back(typed ? typed_r : predict_elevation(p, mask_setting));
    @(negedge clk);
  endtask

  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    while (pending_elev.size() != 0) @(negedge clk);
  endtask

  // Mask writes happen only with the pipeline empty.
  task automatic write_mask(logic signed [MASK_W-1:0] m);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    mask_setting = m;
    mask_writes++;
    @(negedge clk);
  endtask

  initial begin
    logic signed [MASK_W-1:0] seg_mask[6];
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    cycles = 0;
    errors = 0;
    words_checked = 0;
    mask_writes = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    mask_setting = MASK_W'(MASK_RESET);
    sample_ch.valid = 1'b0;
    sample_ch.station_x = '0;
    sample_ch.station_y = '0;
    sample_ch.station_z = '0;
    sample_ch.sat_x = '0;
    sample_ch.sat_y = '0;
    sample_ch.sat_z = '0;
    result_ch.ready = 1'b0;
    seg_mask = '{9000, -9000, 0, 16383, -16384, 0};
    seg_mask[5] = MASK_W'(rand_span(-9000, 9000));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table under the reset mask of ten degrees.
    foreach (dir_rows[i]) send_word(dir_rows[i].p, dir_rows[i].typed, dir_rows[i].r);
    drain_results();

    // Random words: two segments per idling mix, each under its own mask.
    for (int seg = 0; seg < 6; seg++) begin
      tx_idle_pct = (seg < 2) ? 28 : (seg < 4) ? 49 : 0;
      rx_idle_pct = (seg < 2) ? 49 : (seg < 4) ? 28 : 0;
      write_mask(seg_mask[seg]);
      for (int k = 0; k < SEG_LEN; k++) begin
        // Hold the sender off once so the pipeline runs completely dry.
        if (seg == 1 && k == SEG_LEN / 2) begin
          drain_results();
          @(negedge clk);
        end
        send_word(random_geom(), 1'b0, '0);
      end
      drain_results();
    end

    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d elevation words across %0d mask settings,", words_checked,
             mask_writes + 1);
    $display("covering zero vectors, horizon and zenith cases under three stall mixes.");
    if (errors == 0 && pending_elev.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
